@@ hdl/olpd_pkg.sv @@
// Shared types and constants for the opcode/length packet deframer.
package olpd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_ERR_OPC   = 2'd1;
  localparam logic [1:0] KIND_ERR_SHORT = 2'd2;

  // Request function codes
  localparam logic FUNC_STREAM = 1'b0;
  localparam logic FUNC_TBL_WR = 1'b1;

  // Length table geometry
  localparam int TBL_DEPTH = 256;
  localparam int TBL_W     = 16;

  // Shortest legal variable-length packet (opcode plus two length bytes)
  localparam logic [15:0] MIN_VAR_LEN = 16'd3;

  // Mask value after reset
  localparam logic [15:0] MASK_RST = 16'h8000;

  // One result request
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       first;
    logic       last;
  } res_t;

  // Results produced by the parser in one cycle, in delivery order
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
    res_t       r2;
  } push_t;

endpackage

@@ hdl/olpd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module olpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/olpd_parser.sv @@
// Packet parser: classifies stream bytes and produces up to three results per byte.
module olpd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                func,
  input  logic [7:0]          data,
  input  logic [15:0]         entry,
  input  logic [15:0]         mask,
  output olpd_pkg::push_t     push
);
  import olpd_pkg::*;

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic        halt_r, halt_nxt;
  logic [15:0] len;
  push_t       p;

  assign len = {hi_r, data};

  // Classify the current byte
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    op_nxt    = op_r;
    hi_nxt    = hi_r;
    halt_nxt  = halt_r;
    p         = '0;
    if (en && func == FUNC_STREAM && !halt_r) begin
      unique case (phase_r)
        PH_HIGH: begin
          hi_nxt    = data;
          phase_nxt = PH_LOW;
        end
        PH_LOW: begin
          phase_nxt = PH_NONE;
          if (len < MIN_VAR_LEN) begin
            halt_nxt   = 1'b1;
            p.cnt      = 2'd1;
            p.r0.kind  = KIND_ERR_SHORT;
          end else begin
            left_nxt    = len - MIN_VAR_LEN;
            p.cnt       = 2'd3;
            p.r0.kind   = KIND_DATA;
            p.r0.data   = op_r;
            p.r0.first  = 1'b1;
            p.r1.kind   = KIND_DATA;
            p.r1.data   = hi_r;
            p.r2.kind   = KIND_DATA;
            p.r2.data   = data;
            p.r2.last   = (len == MIN_VAR_LEN);
          end
        end
        default: begin
          if (left_r != 16'd0) begin
            // Body byte of a packet in progress
            left_nxt   = left_r - 16'd1;
            p.cnt      = 2'd1;
            p.r0.kind  = KIND_DATA;
            p.r0.data  = data;
            p.r0.last  = (left_r == 16'd1);
          end else if (entry == 16'd0) begin
            halt_nxt   = 1'b1;
            p.cnt      = 2'd1;
            p.r0.kind  = KIND_ERR_OPC;
          end else if ((entry & mask) != 16'd0) begin
            // Hold the opcode until the length is known
            op_nxt    = data;
            phase_nxt = PH_HIGH;
          end else begin
            left_nxt   = entry - 16'd1;
            p.cnt      = 2'd1;
            p.r0.kind  = KIND_DATA;
            p.r0.data  = data;
            p.r0.first = 1'b1;
            p.r0.last  = (entry == 16'd1);
          end
        end
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NONE;
      left_r  <= 16'd0;
      op_r    <= 8'd0;
      hi_r    <= 8'd0;
      halt_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      op_r    <= op_nxt;
      hi_r    <= hi_nxt;
      halt_r  <= halt_nxt;
    end
  end

  assign push = p;

endmodule

@@ hdl/olpd_out_queue.sv @@
// Four-entry result queue that takes up to three results per cycle.
module olpd_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  olpd_pkg::push_t   push,
  input  logic              pop,
  output logic              room,
  output logic              not_empty,
  output olpd_pkg::res_t    head
);
  import olpd_pkg::*;

  res_t       q_r [4];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != 3'd0);
  assign head      = q_r[rd_r];

  // Space for a three-result burst after this cycle's pop
  assign room = (cnt_r <= 3'd1) || (cnt_r == 3'd2 && pop);

  always_comb begin
    wr_nxt  = wr_r + push.cnt;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push.cnt} - {2'b00, pop};
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q_r[wr_r] <= push.r0;
    end
    if (push.cnt >= 2'd2) begin
      q_r[wr_r + 2'd1] <= push.r1;
    end
    if (push.cnt == 2'd3) begin
      q_r[wr_r + 2'd2] <= push.r2;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hdl/opcode_length_packet_deframer_core.sv @@
// Top level of the opcode/length packet deframer.
//
// Input channel (in_valid/in_stall): each request is either a stream byte
// (in_func = 0, in_byte) or a length table write (in_func = 1, in_table_index,
// in_table_value). Output channel (out_valid/out_stall): packet bytes with
// first/last marks, or an error kind. Configuration channel (cfg_valid/
// cfg_ready): writes the variable-length flag mask; always ready.
// One request is accepted per cycle while in_stall is low. The table is read
// at acceptance, the parser works on the registered request once the queue
// has room and writes the output queue, from which the first result leaves.
// A variable packet's low length byte releases three results at once; the
// four-entry output queue absorbs them, so input pauses once per variable
// packet while the receiver keeps up. A stalled receiver fills the queue
// and then holds off new input requests.
// Reset clears the queue, parser state, table valid bits (all opcodes
// unknown) and sets the mask to 0x8000. After an error result the block
// drops stream bytes until reset; table writes are still taken.
module opcode_length_packet_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_byte,
  input  logic [7:0]  in_table_index,
  input  logic [15:0] in_table_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic        out_first_byte,
  output logic        out_last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import olpd_pkg::*;

  logic                 s1_vld_r, s1_vld_nxt;
  logic                 s1_func_r;
  logic [7:0]           s1_byte_r;
  logic [TBL_DEPTH-1:0] tbl_vld_r;
  logic                 ent_vld_r;
  logic [TBL_W-1:0]     ram_rdata;
  logic [TBL_W-1:0]     entry;
  logic [15:0]          mask_r;
  logic                 accept;
  logic                 adv;
  logic                 room;
  logic                 pop;
  push_t                push;
  res_t                 head;

  assign cfg_ready = 1'b1;

  // Stage one advances when empty or when the parser can take its request
  assign adv      = !s1_vld_r || room;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign s1_vld_nxt = adv ? in_valid : s1_vld_r;

  assign entry = ent_vld_r ? ram_rdata : '0;

  olpd_ram #(
    .WIDTH (TBL_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (accept && in_func == FUNC_TBL_WR),
    .waddr (in_table_index),
    .wdata (in_table_value),
    .re    (accept),
    .raddr (in_byte),
    .rdata (ram_rdata)
  );

  // Input register, table valid bits and mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      tbl_vld_r <= '0;
      mask_r    <= MASK_RST;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      if (accept && in_func == FUNC_TBL_WR) begin
        tbl_vld_r[in_table_index] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        mask_r <= cfg_data;
      end
    end
  end

  // Payload of stage one
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r <= in_func;
      s1_byte_r <= in_byte;
      ent_vld_r <= tbl_vld_r[in_byte];
    end
  end

  olpd_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_vld_r && room),
    .func  (s1_func_r),
    .data  (s1_byte_r),
    .entry (entry),
    .mask  (mask_r),
    .push  (push)
  );

  assign pop = out_valid && !out_stall;

  olpd_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .room      (room),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_kind       = head.kind;
  assign out_byte       = head.data;
  assign out_first_byte = head.first;
  assign out_last_byte  = head.last;

endmodule
